// File: hw/rtl/lfsp_pkg.sv
// shared types, constants and helpers for the laser frame stream parser
// no dependencies

package lfsp_pkg;

   // palette store geometry
   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
   localparam int PAL_WIDTH       = 24;

   // record buffer
   localparam int REC_BYTES = 10;
   localparam int REC_AW    = 4;

   // header layout
   localparam int         MAGIC_LEN    = 7;
   localparam logic [4:0] POS_FORMAT   = 5'd7;
   localparam logic [4:0] POS_COUNT_HI = 5'd24;
   localparam logic [4:0] POS_COUNT_LO = 5'd25;
   localparam logic [4:0] POS_HDR_LAST = 5'd31;

   localparam logic [7:0] MAGIC [MAGIC_LEN] = '{8'h49, 8'h4C, 8'h44, 8'h41,
                                                8'h00, 8'h00, 8'h00};

   // record formats
   localparam logic [2:0] FMT_PAL_3D  = 3'd0;
   localparam logic [2:0] FMT_PAL_2D  = 3'd1;
   localparam logic [2:0] FMT_TRUE_3D = 3'd4;
   localparam logic [2:0] FMT_TRUE_2D = 3'd5;

   // blank bits: bit 14 of the palette colour word, bit 6 of the truecolour status
   localparam int BLANK_PAL_BIT  = 6;
   localparam int BLANK_TRUE_BIT = 6;

   // request kinds
   localparam logic REQ_STREAM  = 1'b0;
   localparam logic REQ_PALETTE = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_MAGIC  = 2'd1,
      ERR_FORMAT = 2'd2
   } err_code_type;

   typedef enum logic {
      PH_HEADER,
      PH_RECORD
   } phase_type;

   // point held between the parse stage and the result register
   typedef struct packed {
      err_code_type err;
      logic [15:0]  x;
      logic [15:0]  y;
      logic         last;
      logic         pal;
      logic         blank;
      logic         hit;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
   } point_type;

   function automatic logic [REC_AW-1:0] rec_len(input logic [2:0] fmt);
      logic [REC_AW-1:0] len;
      case (fmt)
         FMT_PAL_2D:  len = REC_AW'(6);
         FMT_TRUE_3D: len = REC_AW'(10);
         default:     len = REC_AW'(8);
      endcase
      return len;
   endfunction

endpackage

// File: hw/rtl/lfsp_req_if.sv
// request channel of the laser frame stream parser: stream bytes and palette writes
// no dependencies

interface lfsp_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] stream_byte;
   logic [7:0] palette_index;
   logic [7:0] palette_red;
   logic [7:0] palette_green;
   logic [7:0] palette_blue;

   modport source (output valid, req_type, stream_byte, palette_index,
                   palette_red, palette_green, palette_blue, input ready);
   modport sink   (input valid, req_type, stream_byte, palette_index,
                   palette_red, palette_green, palette_blue, output ready);
endinterface

// File: hw/rtl/lfsp_rsp_if.sv
// result channel of the laser frame stream parser: points and header errors
// no dependencies

interface lfsp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] x_position;
   logic signed [15:0] y_position;
   logic [15:0]        red_level;
   logic [15:0]        green_level;
   logic [15:0]        blue_level;
   logic [15:0]        intensity;
   logic               frame_last;
   logic [1:0]         error_code;

   modport source (output valid, x_position, y_position, red_level, green_level,
                   blue_level, intensity, frame_last, error_code, input ready);
   modport sink   (input valid, x_position, y_position, red_level, green_level,
                   blue_level, intensity, frame_last, error_code, output ready);
endinterface

// File: hw/rtl/lfsp_ram.sv
// generic single-port-write, single-port-read memory with registered read data
// no dependencies

module lfsp_ram #(
   parameter  int WIDTH = 24,
   parameter  int DEPTH = 256,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/laser_frame_stream_parser.sv
// laser frame stream parser top level: header check, record gathering, colour lookup
// depends on lfsp_pkg, lfsp_req_if, lfsp_rsp_if and lfsp_ram

// Takes one transfer per clock, either a stream byte or a palette entry write, and
// keeps taking one per clock while results drain. A point or header error appears
// on the result channel once the byte that completes it has been parsed into the held
// stage, which issues the palette read, and the registered palette read data has been
// coloured into the result register. The palette is a 256 x 24 memory; a valid bit
// per entry, cleared at reset, makes unwritten entries read as black, so there is
// no clearing pass and the block is ready straight out of reset.
// Palette writes never give a result and never disturb the parse in progress.
module laser_frame_stream_parser (
   input  logic       clock,
   input  logic       reset,
   lfsp_req_if.sink   req_bus,
   lfsp_rsp_if.source rsp_bus
);

   import lfsp_pkg::*;

   // parse state
   phase_type   phase_ff, phase_in;
   logic [4:0]  hdr_count_ff, hdr_count_in;
   logic [2:0]  format_ff, format_in;
   logic [15:0] points_ff, points_in;
   logic [REC_AW-1:0] rec_count_ff, rec_count_in;
   logic [7:0]  rec_bytes_ff [REC_BYTES];
   logic [7:0]  rec_bytes_in [REC_BYTES];
   logic [7:0]  rec_cur [REC_BYTES];

   // palette
   logic [PALETTE_ENTRIES-1:0] pal_valid_ff, pal_valid_in;
   logic                       pal_wr_en;
   logic                       pal_rd_en;
   logic [PAL_AW-1:0]          pal_rd_addr;
   logic [PAL_WIDTH-1:0]       pal_rd_data;

   // stage between parse and result register
   logic      s1_valid_ff, s1_valid_in;
   point_type s1_ff, s1_in;
   logic      s1_load;
   logic      s1_adv;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] x_ff, y_ff, red_ff, green_ff, blue_ff, inten_ff;
   logic        last_ff;
   logic [1:0]  err_ff;

   logic       req_fire;
   logic [7:0] b;
   logic [REC_AW-1:0] rec_inc;
   logic [7:0] col_hi, col_lo;
   logic [7:0] c_red, c_green, c_blue, c_max;

   assign b        = req_bus.stream_byte;
   assign s1_adv   = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign req_fire = req_bus.valid && req_bus.ready;
   assign rec_inc  = rec_count_ff + REC_AW'(1);

   assign pal_wr_en = req_fire && (req_bus.req_type == REQ_PALETTE)
                      && ({1'b0, req_bus.palette_index} < 9'(PALETTE_ENTRIES));

   // record as it stands with the current byte in place
   always_comb begin
      for (int i = 0; i < REC_BYTES; i++) begin
         rec_cur[i] = (REC_AW'(i) == rec_count_ff) ? b : rec_bytes_ff[i];
      end
   end

   // palette colour word of the record
   always_comb begin
      case (format_ff)
         FMT_PAL_2D: begin
            col_hi = rec_cur[4];
            col_lo = rec_cur[5];
         end
         default: begin
            col_hi = rec_cur[6];
            col_lo = rec_cur[7];
         end
      endcase
   end

   assign pal_rd_addr = col_lo[PAL_AW-1:0];

   // parse one stream byte
   always_comb begin
      phase_in     = phase_ff;
      hdr_count_in = hdr_count_ff;
      format_in    = format_ff;
      points_in    = points_ff;
      rec_count_in = rec_count_ff;
      rec_bytes_in = rec_bytes_ff;
      s1_load      = 1'b0;
      s1_in        = '0;
      pal_rd_en    = 1'b0;

      if (req_fire && (req_bus.req_type == REQ_STREAM)) begin
         if (phase_ff == PH_RECORD) begin
            rec_bytes_in[rec_count_ff] = b;
            rec_count_in = rec_inc;
            if (rec_inc == rec_len(format_ff)) begin
               rec_count_in = '0;
               s1_load      = 1'b1;
               s1_in.err    = ERR_NONE;
               s1_in.x      = {rec_cur[0], rec_cur[1]};
               s1_in.y      = {rec_cur[2], rec_cur[3]};
               points_in    = points_ff - 16'd1;
               s1_in.last   = (points_in == 16'd0);
               if (s1_in.last) begin
                  phase_in     = PH_HEADER;
                  hdr_count_in = '0;
               end
               case (format_ff)
                  FMT_PAL_3D, FMT_PAL_2D: begin
                     s1_in.pal   = 1'b1;
                     s1_in.blank = col_hi[BLANK_PAL_BIT];
                     s1_in.hit   = ({1'b0, col_lo} < 9'(PALETTE_ENTRIES))
                                   && pal_valid_ff[pal_rd_addr];
                     pal_rd_en   = 1'b1;
                  end
                  FMT_TRUE_3D: begin
                     s1_in.blank = rec_cur[6][BLANK_TRUE_BIT];
                     s1_in.blue  = rec_cur[7];
                     s1_in.green = rec_cur[8];
                     s1_in.red   = rec_cur[9];
                  end
                  default: begin
                     s1_in.blank = rec_cur[4][BLANK_TRUE_BIT];
                     s1_in.blue  = rec_cur[5];
                     s1_in.green = rec_cur[6];
                     s1_in.red   = rec_cur[7];
                  end
               endcase
            end
         end else begin
            hdr_count_in = hdr_count_ff + 5'd1;
            if (hdr_count_ff < 5'(MAGIC_LEN)) begin
               if (b != MAGIC[hdr_count_ff[2:0]]) begin
                  s1_load      = 1'b1;
                  s1_in.err    = ERR_MAGIC;
                  hdr_count_in = '0;
               end
            end else if (hdr_count_ff == POS_FORMAT) begin
               if (b inside {8'(FMT_PAL_3D), 8'(FMT_PAL_2D), 8'(FMT_TRUE_3D),
                             8'(FMT_TRUE_2D)}) begin
                  format_in = b[2:0];
               end else begin
                  s1_load      = 1'b1;
                  s1_in.err    = ERR_FORMAT;
                  hdr_count_in = '0;
               end
            end else if (hdr_count_ff == POS_COUNT_HI) begin
               points_in = {b, points_ff[7:0]};
            end else if (hdr_count_ff == POS_COUNT_LO) begin
               points_in = {points_ff[15:8], b};
            end else if (hdr_count_ff == POS_HDR_LAST) begin
               // empty frame stays in header search
               if (points_ff != 16'd0) begin
                  phase_in     = PH_RECORD;
                  rec_count_in = '0;
               end
            end
         end
      end
   end

   always_comb begin
      pal_valid_in = pal_valid_ff;
      if (pal_wr_en) begin
         pal_valid_in[req_bus.palette_index[PAL_AW-1:0]] = 1'b1;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   lfsp_ram #(
      .WIDTH (PAL_WIDTH),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (req_bus.palette_index[PAL_AW-1:0]),
      .wr_data ({req_bus.palette_red, req_bus.palette_green, req_bus.palette_blue}),
      .rd_en   (pal_rd_en),
      .rd_addr (pal_rd_addr),
      .rd_data (pal_rd_data)
   );

   // colour the held point
   always_comb begin
      if (s1_ff.pal) begin
         c_red   = s1_ff.hit ? pal_rd_data[23:16] : 8'd0;
         c_green = s1_ff.hit ? pal_rd_data[15:8]  : 8'd0;
         c_blue  = s1_ff.hit ? pal_rd_data[7:0]   : 8'd0;
      end else begin
         c_red   = s1_ff.red;
         c_green = s1_ff.green;
         c_blue  = s1_ff.blue;
      end
      if (s1_ff.blank || (s1_ff.err != ERR_NONE)) begin
         c_red   = 8'd0;
         c_green = 8'd0;
         c_blue  = 8'd0;
      end
      c_max = c_red;
      if (c_green > c_max) begin
         c_max = c_green;
      end
      if (c_blue > c_max) begin
         c_max = c_blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_count_ff <= '0;
         format_ff    <= '0;
         points_ff    <= '0;
         rec_count_ff <= '0;
         pal_valid_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hdr_count_ff <= hdr_count_in;
         format_ff    <= format_in;
         points_ff    <= points_in;
         rec_count_ff <= rec_count_in;
         pal_valid_ff <= pal_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_bytes_ff <= rec_bytes_in;
      if (s1_load) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         x_ff     <= s1_ff.x;
         y_ff     <= s1_ff.y;
         red_ff   <= {c_red, 8'h00};
         green_ff <= {c_green, 8'h00};
         blue_ff  <= {c_blue, 8'h00};
         inten_ff <= {c_max, 8'h00};
         last_ff  <= s1_ff.last;
         err_ff   <= s1_ff.err;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.x_position  = x_ff;
   assign rsp_bus.y_position  = y_ff;
   assign rsp_bus.red_level   = red_ff;
   assign rsp_bus.green_level = green_ff;
   assign rsp_bus.blue_level  = blue_ff;
   assign rsp_bus.intensity   = inten_ff;
   assign rsp_bus.frame_last  = last_ff;
   assign rsp_bus.error_code  = err_ff;

endmodule

// File: test/laser_frame_stream_parser_test.sv
// self-checking testbench for laser_frame_stream_parser: header errors, all four record
// formats, palette writes, with random idling on both channels
// depends on lfsp_pkg, lfsp_req_if, lfsp_rsp_if and the parser rtl

module laser_frame_stream_parser_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lfsp_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam logic [2:0] FORMATS [4] = '{FMT_PAL_3D, FMT_PAL_2D, FMT_TRUE_3D, FMT_TRUE_2D};

   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [7:0] idx;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_item_type;

   typedef struct packed {
      logic [15:0]  x;
      logic [15:0]  y;
      logic [15:0]  red;
      logic [15:0]  green;
      logic [15:0]  blue;
      logic [15:0]  inten;
      logic         last;
      err_code_type code;
   } point_res_type;

   typedef struct {
      req_item_type it;
      err_code_type want;
   } opening_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lfsp_req_if req_bus ();
   lfsp_rsp_if rsp_bus ();

   laser_frame_stream_parser u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // parser state as predicted
   phase_type   parse_ph;
   logic [4:0]  hdr_pos;
   logic [2:0]  cur_fmt;
   logic [15:0] pts_left;
   logic [3:0]  rec_pos;
   logic [7:0]  rec [REC_BYTES];
   logic [23:0] pal_mem [PALETTE_ENTRIES];

   point_res_type   points_due [$];
   opening_row_type opening_rows [$];

   int src_idle  = 0;
   int sink_idle = 0;
   int items_sent, due_count, frames_sent, empty_frames, palette_writes;
   int pts_seen, lasts_seen, errs_seen, mismatches;

   function automatic int point_bytes(input logic [2:0] fmt);
      if (fmt == FMT_PAL_2D) return 6;
      if (fmt == FMT_TRUE_3D) return 10;
      return 8;
   endfunction

   function automatic bit is_format(input logic [7:0] b);
      return b == 8'(FMT_PAL_3D) || b == 8'(FMT_PAL_2D) ||
             b == 8'(FMT_TRUE_3D) || b == 8'(FMT_TRUE_2D);
   endfunction

   // advances the predicted parser by one transfer; returns 1 when a result is due
   function automatic bit parse_item(input req_item_type it, output point_res_type res);
      logic [4:0]  pos;
      logic [3:0]  base;
      logic [7:0]  hi, lo, r, g, b;
      logic        blank;
      logic [15:0] rl, gl, bl, mx;
      res = '0;
      if (it.kind == REQ_PALETTE) begin
         pal_mem[it.idx] = {it.red, it.green, it.blue};
         return 1'b0;
      end
      if (parse_ph == PH_HEADER) begin
         pos = hdr_pos;
         if (pos < MAGIC_LEN) begin
            if (it.data != MAGIC[pos]) begin
               res.code = ERR_MAGIC;
               hdr_pos  = '0;
               return 1'b1;
            end
         end else if (pos == POS_FORMAT) begin
            if (!is_format(it.data)) begin
               res.code = ERR_FORMAT;
               hdr_pos  = '0;
               return 1'b1;
            end
            cur_fmt = it.data[2:0];
         end else if (pos == POS_COUNT_HI) begin
            pts_left[15:8] = it.data;
         end else if (pos == POS_COUNT_LO) begin
            pts_left[7:0] = it.data;
         end
         hdr_pos = pos + 5'd1;
         // an empty frame simply wraps back to header search
         if (pos == POS_HDR_LAST && pts_left != 16'd0) begin
            parse_ph = PH_RECORD;
            rec_pos  = '0;
         end
         return 1'b0;
      end
      rec[rec_pos] = it.data;
      rec_pos = rec_pos + 4'd1;
      if (int'(rec_pos) < point_bytes(cur_fmt)) return 1'b0;
      rec_pos = '0;
      if (cur_fmt == FMT_PAL_3D || cur_fmt == FMT_PAL_2D) begin
         hi = (cur_fmt == FMT_PAL_3D) ? rec[6] : rec[4];
         lo = (cur_fmt == FMT_PAL_3D) ? rec[7] : rec[5];
         blank = hi[BLANK_PAL_BIT];
         {r, g, b} = pal_mem[lo];
      end else begin
         base  = (cur_fmt == FMT_TRUE_3D) ? 4'd6 : 4'd4;
         blank = rec[base][BLANK_TRUE_BIT];
         b = rec[base + 4'd1];
         g = rec[base + 4'd2];
         r = rec[base + 4'd3];
      end
      if (blank) {r, g, b} = '0;
      rl = {r, 8'h00};
      gl = {g, 8'h00};
      bl = {b, 8'h00};
      mx = rl;
      if (gl > mx) mx = gl;
      if (bl > mx) mx = bl;
      res.x     = {rec[0], rec[1]};
      res.y     = {rec[2], rec[3]};
      res.red   = rl;
      res.green = gl;
      res.blue  = bl;
      res.inten = mx;
      pts_left  = pts_left - 16'd1;
      res.last  = (pts_left == 16'd0);
      if (res.last) begin
         parse_ph = PH_HEADER;
         hdr_pos  = '0;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] want,
                                  input logic [15:0] got);
      mismatches++;
      $display("%0t ns: mismatch on %s, expected %h, got %h", $time, what, want, got);
   endtask

   // one transfer on the request channel, predicted once accepted
   task automatic put_item(input req_item_type it, input err_code_type typed_err = ERR_NONE);
      point_res_type res;
      bit            has;
      while ($urandom_range(0, 99) < src_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.req_type      <= it.kind;
      req_bus.stream_byte   <= it.data;
      req_bus.palette_index <= it.idx;
      req_bus.palette_red   <= it.red;
      req_bus.palette_green <= it.green;
      req_bus.palette_blue  <= it.blue;
      do @(posedge clock); while (!req_bus.ready);
      has = parse_item(it, res);
      // error rows of the opening table carry their result written out
      if (typed_err != ERR_NONE) begin
         res      = '0;
         res.code = typed_err;
         has      = 1'b1;
      end
      if (has) begin
         points_due.push_back(res);
         due_count++;
      end
      items_sent++;
      if (it.kind == REQ_PALETTE) palette_writes++;
   endtask

   function automatic logic [7:0] pal_index();
      return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 15));
   endfunction

   function automatic req_item_type palette_item(input logic [7:0] idx, input logic [7:0] r,
                                                 input logic [7:0] g, input logic [7:0] b);
      req_item_type it;
      it.kind  = REQ_PALETTE;
      it.data  = 8'($urandom_range(0, 255));
      it.idx   = idx;
      it.red   = r;
      it.green = g;
      it.blue  = b;
      return it;
   endfunction

   function automatic req_item_type stream_item(input logic [7:0] b);
      req_item_type it;
      it.kind  = REQ_STREAM;
      it.data  = b;
      it.idx   = 8'($urandom_range(0, 255));
      it.red   = 8'($urandom_range(0, 255));
      it.green = 8'($urandom_range(0, 255));
      it.blue  = 8'($urandom_range(0, 255));
      return it;
   endfunction

   // stream byte, now and then preceded by a palette write
   task automatic put_stream(input logic [7:0] b);
      if ($urandom_range(0, 99) < 6)
         put_item(palette_item(pal_index(), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
      put_item(stream_item(b));
   endtask

   // well-formed header and records; cut drops bytes off the tail of the last record
   task automatic send_frame(input logic [2:0] fmt, input logic [15:0] count, input int cut);
      int         len, total, k, flag_at;
      logic [7:0] b;
      len     = point_bytes(fmt);
      flag_at = (fmt == FMT_PAL_3D || fmt == FMT_TRUE_3D) ? 6 : 4;
      for (int i = 0; i < 32; i++) begin
         if (i < MAGIC_LEN) b = MAGIC[i];
         else if (i == 7) b = 8'(fmt);
         else if (i == 24) b = count[15:8];
         else if (i == 25) b = count[7:0];
         else b = 8'($urandom_range(0, 255));
         put_stream(b);
      end
      total = int'(count) * len;
      if (cut < total) total = total - cut;
      for (int n = 0; n < total; n++) begin
         k = n % len;
         b = 8'($urandom_range(0, 255));
         if (k == flag_at) b[6] = ($urandom_range(0, 3) == 0);
         else if (k == flag_at + 1 && (fmt == FMT_PAL_3D || fmt == FMT_PAL_2D))
            b = pal_index();
         put_stream(b);
      end
      frames_sent++;
      if (count == 16'd0) empty_frames++;
   endtask

   // brings the parser back to the first header byte
   task automatic resync();
      while (!(parse_ph == PH_HEADER && hdr_pos == 5'd0))
         put_stream(parse_ph == PH_RECORD ? 8'($urandom_range(0, 255)) : 8'h00);
   endtask

   task automatic add_stream(input logic [7:0] b, input err_code_type want = ERR_NONE);
      opening_row_type row;
      row.it   = stream_item(b);
      row.want = want;
      opening_rows.push_back(row);
   endtask

   task automatic add_palette(input logic [7:0] idx, input logic [7:0] r,
                              input logic [7:0] g, input logic [7:0] b);
      opening_row_type row;
      row.it   = palette_item(idx, r, g, b);
      row.want = ERR_NONE;
      opening_rows.push_back(row);
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= sink_idle);
      end
   end

   always @(posedge clock) begin : result_check
      point_res_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.x     = rsp_bus.x_position;
         got.y     = rsp_bus.y_position;
         got.red   = rsp_bus.red_level;
         got.green = rsp_bus.green_level;
         got.blue  = rsp_bus.blue_level;
         got.inten = rsp_bus.intensity;
         got.last  = rsp_bus.frame_last;
         got.code  = err_code_type'(rsp_bus.error_code);
         if (got.code == ERR_NONE) pts_seen++;
         else errs_seen++;
         if (got.code == ERR_NONE && got.last) lasts_seen++;
         if (points_due.size() == 0) begin
            report_mismatch("result with nothing due, error_code", 16'd0, 16'(got.code));
         end else begin
            want = points_due.pop_front();
            if (got.x !== want.x) report_mismatch("x_position", want.x, got.x);
            if (got.y !== want.y) report_mismatch("y_position", want.y, got.y);
            if (got.red !== want.red) report_mismatch("red_level", want.red, got.red);
            if (got.green !== want.green)
               report_mismatch("green_level", want.green, got.green);
            if (got.blue !== want.blue) report_mismatch("blue_level", want.blue, got.blue);
            if (got.inten !== want.inten)
               report_mismatch("intensity", want.inten, got.inten);
            if (got.last !== want.last)
               report_mismatch("frame_last", 16'(want.last), 16'(got.last));
            if (got.code !== want.code)
               report_mismatch("error_code", 16'(want.code), 16'(got.code));
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("no transfer for %0d cycles, %0d results outstanding", STALL_LIMIT,
               points_due.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int start_items, start_due, pick, k, cut;
      logic [7:0]  b;
      logic [15:0] count;
      req_bus.valid         <= 1'b0;
      req_bus.req_type      <= REQ_STREAM;
      req_bus.stream_byte   <= 8'h00;
      req_bus.palette_index <= 8'h00;
      req_bus.palette_red   <= 8'h00;
      req_bus.palette_green <= 8'h00;
      req_bus.palette_blue  <= 8'h00;
      parse_ph = PH_HEADER;
      hdr_pos  = '0;
      cur_fmt  = '0;
      pts_left = '0;
      rec_pos  = '0;
      foreach (rec[i]) rec[i] = '0;
      foreach (pal_mem[i]) pal_mem[i] = '0;

      // opening table: palette extremes, magic and format errors
      add_palette(8'h00, 8'hFF, 8'hFF, 8'hFF);
      add_palette(8'hFF, 8'h00, 8'h00, 8'h00);
      add_palette(8'h0F, 8'h80, 8'h01, 8'h7F);
      add_stream(8'h00, ERR_MAGIC);
      add_stream(8'hFF, ERR_MAGIC);
      for (int i = 0; i < 6; i++) add_stream(MAGIC[i]);
      add_stream(8'h01, ERR_MAGIC);
      for (int i = 0; i < MAGIC_LEN; i++) begin
         add_stream(MAGIC[i]);
         if (i == 1) add_palette(8'h03, 8'h55, 8'hAA, 8'hC3);
      end
      add_stream(8'h02, ERR_FORMAT);
      add_stream(MAGIC[0]);
      add_stream(MAGIC[0], ERR_MAGIC);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      src_idle  = 21;
      sink_idle = 61;
      foreach (opening_rows[i]) put_item(opening_rows[i].it, opening_rows[i].want);

      for (int ph = 0; ph < 3; ph++) begin
         src_idle  = (ph == 0) ? 21 : (ph == 1) ? 61 : 0;
         sink_idle = (ph == 0) ? 61 : (ph == 1) ? 21 : 0;
         start_items = items_sent;
         start_due   = due_count;
         while (items_sent - start_items < 135 || due_count - start_due < 25) begin
            resync();
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               k = $urandom_range(0, MAGIC_LEN - 1);
               for (int i = 0; i < k; i++) put_stream(MAGIC[i]);
               put_stream(MAGIC[k] ^ 8'($urandom_range(1, 255)));
            end else if (pick == 1) begin
               for (int i = 0; i < MAGIC_LEN; i++) put_stream(MAGIC[i]);
               do b = 8'($urandom_range(0, 255)); while (is_format(b));
               put_stream(b);
            end else if (pick == 2) begin
               repeat ($urandom_range(1, 6)) put_stream(8'($urandom_range(0, 255)));
            end else begin
               count = (frames_sent % 5 == 4) ? 16'd0 : 16'($urandom_range(1, 4));
               cut   = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
               send_frame(FORMATS[frames_sent % 4], count, cut);
            end
         end
      end
      req_bus.valid <= 1'b0;

      while (points_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("sent %0d transfers, %0d of them palette writes, across %0d frames (%0d empty)",
               items_sent, palette_writes, frames_sent, empty_frames);
      $display("compared %0d points (%0d closing a frame) and %0d header errors, %0d mismatches",
               pts_seen, lasts_seen, errs_seen, mismatches);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
